FILE: design/rgb_box_mean_filter_unit_defines.svh
// assertion macros used by the port checker file
`ifndef RGB_BOX_MEAN_FILTER_UNIT_DEFINES_SVH
`define RGB_BOX_MEAN_FILTER_UNIT_DEFINES_SVH

// next-cycle implication, sampled on clk, quiet during reset
`define RBMF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rbmf check failed");

// same-cycle implication, sampled on clk, quiet during reset
`define RBMF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rbmf check failed");

`endif

FILE: design/rbmf_pkg.sv
// shared constants and types of the rgb box mean filter
`default_nettype none
package rbmf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 4;
  localparam int MAX_HEIGHT = 4096;
  localparam int RING_ROWS  = 3 * MAX_RADIUS + 1;

  localparam int PIX_W  = 8;
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int RCFG_W = 3;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = $clog2(RING_ROWS);
  localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(WIN_MAX * 255 + 1);
  localparam int DIVR_W = $clog2(WIN_MAX + 1);
  localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int TOT_W  = WCFG_W + HCFG_W;
  localparam int CNT_W  = TOT_W + 1;
  localparam int DLY_W  = WCFG_W + RCFG_W + 1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [PIX_W-1:0] pix_t;
endpackage
`default_nettype wire

FILE: design/rgb_box_mean_filter_unit.sv
// rgb box mean filter top level: line store, window walk, divide, output
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | in_red, in_green, in_blue, in_flush
//  out     | source    | out_valid/out_stall| out_mean_red/green/blue, out_frame_end
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// an item that gives no result leaves the sequencer in idle; an item that gives a
// result passes through the walk, drain, divide and output states and waits on out_stall,
// paced by the one read port of the line store walked pixel by pixel and the
// bit-serial divider. reset is synchronous on rst_n; the line store is not cleared.
// in_stall stays high while an item is in work, in the cycle after a cfg write
// and in the first cycle after reset.
`default_nettype none
module rgb_box_mean_filter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rbmf_pkg::pix_t              in_red,
  input  wire rbmf_pkg::pix_t              in_green,
  input  wire rbmf_pkg::pix_t              in_blue,
  input  wire logic                        in_flush,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rbmf_pkg::pix_t                   out_mean_red,
  output rbmf_pkg::pix_t                   out_mean_green,
  output rbmf_pkg::pix_t                   out_mean_blue,
  output logic                             out_frame_end,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rbmf_pkg::HCFG_W-1:0] cfg_data
);
  import rbmf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers and derived frame constants
  logic [WCFG_W-1:0] wcfg_r;
  logic [HCFG_W-1:0] hcfg_r;
  logic [RCFG_W-1:0] rcfg_r;
  logic [WCFG_W-1:0] eff_w;
  logic [HCFG_W-1:0] eff_h;
  logic [RCFG_W-1:0] eff_r;
  logic [TOT_W-1:0]  tot_r;
  logic [DLY_W-1:0]  dly_r;
  logic              settle_r;
  logic              cfg_wr;
  logic              cfg_known;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // only a write to a known register restarts the frame
  assign cfg_known = cfg_wr && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS});

  always_comb begin
    if (wcfg_r == '0) eff_w = WCFG_W'(1);
    else if (wcfg_r > WCFG_W'(MAX_WIDTH)) eff_w = WCFG_W'(MAX_WIDTH);
    else eff_w = wcfg_r;
    if (hcfg_r == '0) eff_h = HCFG_W'(1);
    else if (hcfg_r > HCFG_W'(MAX_HEIGHT)) eff_h = HCFG_W'(MAX_HEIGHT);
    else eff_h = hcfg_r;
    if (rcfg_r > RCFG_W'(MAX_RADIUS)) eff_r = RCFG_W'(MAX_RADIUS);
    else eff_r = rcfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcfg_r   <= WCFG_W'(640);
      hcfg_r   <= HCFG_W'(480);
      rcfg_r   <= RCFG_W'(4);
      settle_r <= 1'b1;
    end else begin
      settle_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_WIDTH:  wcfg_r <= cfg_data[WCFG_W-1:0];
          REG_HEIGHT: hcfg_r <= cfg_data;
          REG_RADIUS: rcfg_r <= cfg_data[RCFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // frame constants, registered from the clamped configuration values
  always_ff @(posedge clk) begin
    tot_r <= TOT_W'(eff_w * eff_h);
    dly_r <= DLY_W'(eff_r * eff_w) + DLY_W'(eff_r);
  end

  // stream position state
  logic [COL_W-1:0]  col_r;
  logic [SLOT_W-1:0] wslot_r;
  logic [CNT_W-1:0]  icnt_r;
  logic [CNT_W-1:0]  ocnt_r;
  logic [ROW_W-1:0]  oy_r;
  logic [COL_W-1:0]  ox_r;
  logic [SLOT_W-1:0] oslot_r;

  logic in_acc, frame_in, ignore, wr_en, due, last;
  logic [CNT_W-1:0] icnt_inc;

  assign in_stall = !(state_r == S_IDLE) || settle_r;
  assign in_acc   = in_valid && !in_stall;
  assign frame_in = icnt_r >= CNT_W'(tot_r);
  assign ignore   = in_flush && !frame_in;
  assign wr_en    = in_acc && !frame_in && !in_flush;
  assign icnt_inc = icnt_r + CNT_W'(1);
  assign due      = !ignore && (ocnt_r < CNT_W'(tot_r)) &&
                    (icnt_inc >= ocnt_r + CNT_W'(dly_r) + CNT_W'(1));
  assign last     = (ocnt_r + CNT_W'(1)) >= CNT_W'(tot_r);

  // window bounds of the pixel whose result is due
  logic [ROW_W-1:0]  y0, y1;
  logic [COL_W-1:0]  x0, x1;
  logic [ROW_W:0]    ysum;
  logic [COL_W:0]    xsum;
  logic [SPAN_W-1:0] ny, nx;
  logic [SLOT_W:0]   s0_raw;
  logic [SLOT_W-1:0] s0;

  always_comb begin
    y0   = (oy_r >= ROW_W'(eff_r)) ? oy_r - ROW_W'(eff_r) : '0;
    ysum = {1'b0, oy_r} + (ROW_W + 1)'(eff_r);
    y1   = ((ROW_W + 1)'(ysum) < (ROW_W + 1)'(eff_h)) ? ysum[ROW_W-1:0]
                                                     : ROW_W'(eff_h - HCFG_W'(1));
    x0   = (ox_r >= COL_W'(eff_r)) ? ox_r - COL_W'(eff_r) : '0;
    xsum = {1'b0, ox_r} + (COL_W + 1)'(eff_r);
    x1   = (xsum < (COL_W + 1)'(eff_w)) ? xsum[COL_W-1:0]
                                       : COL_W'(eff_w - WCFG_W'(1));
    ny   = SPAN_W'(y1 - y0) + SPAN_W'(1);
    nx   = SPAN_W'(x1 - x0) + SPAN_W'(1);
    // ring slot of the top window row
    s0_raw = {1'b0, oslot_r} - (SLOT_W + 1)'(oy_r - y0);
    s0     = s0_raw[SLOT_W] ? SLOT_W'(s0_raw + (SLOT_W + 1)'(RING_ROWS))
                            : s0_raw[SLOT_W-1:0];
  end

  // counters and positions
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_known) begin
      col_r   <= '0;
      wslot_r <= '0;
      icnt_r  <= '0;
      ocnt_r  <= '0;
      oy_r    <= '0;
      ox_r    <= '0;
      oslot_r <= '0;
    end else if (in_acc && !ignore) begin
      if (due && last) begin
        col_r   <= '0;
        wslot_r <= '0;
        icnt_r  <= '0;
        ocnt_r  <= '0;
        oy_r    <= '0;
        ox_r    <= '0;
        oslot_r <= '0;
      end else begin
        icnt_r <= icnt_inc;
        if (wr_en) begin
          if (WCFG_W'(col_r) + WCFG_W'(1) >= eff_w) begin
            col_r   <= '0;
            wslot_r <= (wslot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : wslot_r + SLOT_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
        end
        if (due) begin
          ocnt_r <= ocnt_r + CNT_W'(1);
          if (WCFG_W'(ox_r) + WCFG_W'(1) >= eff_w) begin
            ox_r    <= '0;
            oy_r    <= oy_r + ROW_W'(1);
            oslot_r <= (oslot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : oslot_r + SLOT_W'(1);
          end else begin
            ox_r <= ox_r + COL_W'(1);
          end
        end
      end
    end
  end

  // walk registers
  logic [ROW_W-1:0]  wy_r, wy1_r;
  logic [COL_W-1:0]  wx_r, wx0_r, wx1_r;
  logic [SLOT_W-1:0] rslot_r;
  logic [DIVR_W-1:0] wcnt_r;
  logic              fe_r;
  logic              walk_end;

  assign walk_end = (wx_r == wx1_r) && (wy_r == wy1_r);

  always_ff @(posedge clk) begin
    if (in_acc && due) begin
      wy_r    <= y0;
      wy1_r   <= y1;
      wx_r    <= x0;
      wx0_r   <= x0;
      wx1_r   <= x1;
      rslot_r <= s0;
      wcnt_r  <= DIVR_W'(ny * nx);
      fe_r    <= last;
    end else if (state_r == S_WALK) begin
      if (wx_r == wx1_r) begin
        wx_r <= wx0_r;
        if (wy_r != wy1_r) begin
          wy_r    <= wy_r + ROW_W'(1);
          rslot_r <= (rslot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : rslot_r + SLOT_W'(1);
        end
      end else begin
        wx_r <= wx_r + COL_W'(1);
      end
    end
  end

  // line store: one write port, one registered read port
  logic [3*PIX_W-1:0] line_mem [MEM_DEPTH];
  logic [3*PIX_W-1:0] rd_q_r;
  logic               rd_vld_r;
  logic [ADDR_W-1:0]  waddr, raddr;

  assign waddr = ADDR_W'(wslot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
  assign raddr = ADDR_W'(rslot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wx_r);

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[waddr] <= {in_red, in_green, in_blue};
  end

  always_ff @(posedge clk) begin
    rd_q_r <= line_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= (state_r == S_WALK);
  end

  // window accumulation
  sum_t sum_r [3];
  always_ff @(posedge clk) begin
    if (in_acc && due) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
    end else if (rd_vld_r) begin
      sum_r[0] <= sum_r[0] + SUM_W'(rd_q_r[3*PIX_W-1:2*PIX_W]);
      sum_r[1] <= sum_r[1] + SUM_W'(rd_q_r[2*PIX_W-1:PIX_W]);
      sum_r[2] <= sum_r[2] + SUM_W'(rd_q_r[PIX_W-1:0]);
    end
  end

  // divide by the window pixel count
  logic div_start_r, div_done;
  pix_t quot [3];

  always_ff @(posedge clk) begin
    if (!rst_n) div_start_r <= 1'b0;
    else        div_start_r <= (state_r == S_DRAIN);
  end

  rbmf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (sum_r),
    .divisor  (wcnt_r),
    .done     (div_done),
    .quotient (quot)
  );

  // output register
  pix_t mr_r, mg_r, mb_r;
  logic of_r;
  always_ff @(posedge clk) begin
    if (div_done) begin
      mr_r <= quot[0];
      mg_r <= quot[1];
      mb_r <= quot[2];
      of_r <= fe_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && due) state_nxt = S_WALK;
      S_WALK:  if (walk_end) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_mean_red   = mr_r;
  assign out_mean_green = mg_r;
  assign out_mean_blue  = mb_r;
  assign out_frame_end  = of_r;
endmodule
`default_nettype wire

FILE: design/rbmf_divider.sv
// three-lane restoring divider, one quotient bit per cycle
`default_nettype none
module rbmf_divider (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire rbmf_pkg::sum_t       dividend [3],
  input  wire logic [rbmf_pkg::DIVR_W-1:0] divisor,
  output logic                      done,
  output rbmf_pkg::pix_t            quotient [3]
);
  import rbmf_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic [ITER_W-1:0] iter_r;
  logic              done_r;
  sum_t              q_r   [3];
  logic [DIVR_W-1:0] rem_r [3];
  logic [DIVR_W-1:0] dv_r;

  // control: count the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        if (iter_r == ITER_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        iter_r <= iter_r + ITER_W'(1);
      end
    end
  end

  // datapath: shift, trial subtract, keep
  always_ff @(posedge clk) begin
    if (start) begin
      dv_r <= divisor;
      for (int c = 0; c < 3; c++) begin
        q_r[c]   <= dividend[c];
        rem_r[c] <= '0;
      end
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        if ({rem_r[c], q_r[c][SUM_W-1]} >= {1'b0, dv_r}) begin
          rem_r[c] <= DIVR_W'({rem_r[c], q_r[c][SUM_W-1]} - {1'b0, dv_r});
          q_r[c]   <= {q_r[c][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[c] <= DIVR_W'({rem_r[c], q_r[c][SUM_W-1]});
          q_r[c]   <= {q_r[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 3; c++) quotient[c] = q_r[c][PIX_W-1:0];
  end
endmodule
`default_nettype wire

FILE: design/rbmf_checker.sv
// port-level checks of the rgb box mean filter, bound to the top level
`default_nettype none
`include "rgb_box_mean_filter_unit_defines.svh"
module rbmf_port_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rbmf_pkg::pix_t      out_mean_red,
  input wire rbmf_pkg::pix_t      out_mean_green,
  input wire rbmf_pkg::pix_t      out_mean_blue,
  input wire logic                out_frame_end
);
  // a stalled result beat stays
  `RBMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // a stalled result beat keeps its payload
  `RBMF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_mean_red) && $stable(out_mean_green) && $stable(out_mean_blue) && $stable(out_frame_end))
  // no input is taken while a result waits
  `RBMF_ASSERT_NOW(a_one_at_a_time, out_valid, in_stall)
  // a result never shows in the cycle after an input beat
  `RBMF_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !out_valid)
endmodule

bind rgb_box_mean_filter_unit rbmf_port_checker u_rbmf_checker (.*);
`default_nettype wire
